FILE: hw/rtl/sent_packet_ack_loss_tracker_assert.svh
// Assertion macros used by the checker file
`ifndef SENT_PACKET_ACK_LOSS_TRACKER_ASSERT_SVH
`define SENT_PACKET_ACK_LOSS_TRACKER_ASSERT_SVH
// implication checked on every rising clock edge outside reset
`define SPAL_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// implication whose consequent is checked in the cycle after the antecedent
`define SPAL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

FILE: hw/rtl/spal_pkg.sv
// ----------------------------------------------------------------------------
// spal_pkg
// Types and constants of the sent-packet ack and loss tracker.
// ----------------------------------------------------------------------------
package spal_pkg;
   localparam int TableDepth = 32;
   localparam int IdxW = $clog2(TableDepth);
   localparam int CntW = $clog2(TableDepth + 1);

   localparam logic [1:0] CMD_SENT = 2'd0;
   localparam logic [1:0] CMD_ACK  = 2'd1;
   localparam logic [1:0] CMD_LOST = 2'd2;
   // unused code: accepted and dropped without a response
   localparam logic [1:0] CMD_NONE = 2'd3;

   localparam logic [1:0] KIND_ACKED   = 2'd0;
   localparam logic [1:0] KIND_SUMMARY = 2'd1;
   localparam logic [1:0] KIND_SENT    = 2'd2;
   localparam logic [1:0] KIND_LOST    = 2'd3;

   localparam logic REG_REORDER = 1'b0;
   localparam logic REG_TIMELOSS = 1'b1;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [31:0] pkt_number;
      logic [15:0] pkt_size;
      logic [31:0] time_stamp;
      logic        counts_in_flight;
      logic [31:0] gap_bound;
      logic        gap_valid;
      logic        first_block;
      logic        last_block;
      logic [31:0] time_threshold;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] out_number;
      logic [15:0] out_size;
      logic [5:0]  lost_count;
      logic [20:0] bytes_in_flight;
      logic        ok_flag;
      logic        last;
   } rsp_type;

   // entry record held in the table memory (flags kept apart)
   typedef struct packed {
      logic [31:0] number;
      logic [15:0] size;
      logic [31:0] sent_time;
      logic [31:0] ack_time;
   } entry_type;

   // flags: bit0 acked, bit1 lost, bit2 in flight
   typedef logic [2:0] flags_type;
endpackage

FILE: hw/rtl/sent_packet_ack_loss_tracker.sv
// ----------------------------------------------------------------------------
// sent_packet_ack_loss_tracker
// Sent-packet table with ack block processing and loss detection.
// ----------------------------------------------------------------------------
// One request at a time: req_ready stays low from acceptance until the last
// response of the request has been taken. A sent record answers in the cycle
// after acceptance, so with a ready receiver the next request can follow once
// that response is taken; an unknown command gives no response and the next
// request can follow in the next cycle. An ack block or mark-lost walks the
// table through a memory with one read and one write port and a registered
// read, one entry per cycle while no acked-packet response stalls the walk.
// An ack block walks from newest to oldest; each newly acked entry waits until
// its acked-packet response is taken, then the walk closes. On a last block a
// loss scan and the removal of acked, not lost head entries follow; every
// block ends with a summary scan before the summary is offered. Flags sit in
// flip-flops cleared by reset; the data memory needs no clearing.
module sent_packet_ack_loss_tracker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  spal_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output spal_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [7:0]        csr_wdata
);
   import spal_pkg::*;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_ACK   = 4'd1;
   localparam logic [3:0] ST_ACKW  = 4'd2;
   localparam logic [3:0] ST_LOSS  = 4'd3;
   localparam logic [3:0] ST_CLEAN = 4'd4;
   localparam logic [3:0] ST_SUM   = 4'd5;
   localparam logic [3:0] ST_MARK  = 4'd6;
   localparam logic [3:0] ST_OUT   = 4'd7;

   // configuration
   logic [7:0] reorder_ff;
   logic       tloss_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         reorder_ff <= 8'd3;
         tloss_ff   <= 1'b0;
      end else if (csr_we) begin
         if (csr_index == REG_REORDER) reorder_ff <= csr_wdata;
         else tloss_ff <= csr_wdata[0];
      end
   end

   // memories: entry data (registered read), flags in flip-flops
   entry_type mem [TableDepth];
   entry_type rd_ff;
   flags_type flags_ff [TableDepth];
   logic [IdxW-1:0] raddr;
   logic            mem_we;
   logic [IdxW-1:0] waddr;
   entry_type       wdata;
   always_ff @(posedge clock) begin
      if (mem_we) mem[waddr] <= wdata;
      rd_ff <= mem[raddr];
   end

   logic [3:0]      state_ff;
   req_type         req_ff;
   logic [IdxW-1:0] head_ff;
   logic [CntW-1:0] count_ff;
   logic [31:0]     largest_ff;
   // walk position: entries remaining (descending) or done (ascending)
   logic [CntW-1:0] pos_ff;
   logic            rdv_ff;      // rd_ff holds entry at rdi_ff
   logic [IdxW-1:0] rdi_ff;
   logic            lostm_ff, outst_ff;
   logic [31:0]     refack_ff;
   logic [5:0]      lostc_ff;
   logic [20:0]     bif_ff;
   logic            found_ff;
   logic            rsp_valid_ff;
   rsp_type         rsp_ff;

   logic [IdxW-1:0] cur_slot;
   assign cur_slot = head_ff + pos_ff[IdxW-1:0] - IdxW'(1);

   assign req_ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   flags_type cf;
   logic signed [33:0] tdiff;
   logic dist_hit, time_hit;
   assign cf = flags_ff[rdi_ff];
   assign dist_hit = (largest_ff - rd_ff.number) >= {24'd0, reorder_ff};
   assign tdiff = $signed({2'b00, refack_ff}) - $signed({2'b00, rd_ff.sent_time});
   assign time_hit = tloss_ff && (tdiff >= $signed({2'b00, req_ff.time_threshold}));

   always_comb begin
      raddr  = cur_slot;
      mem_we = 1'b0;
      waddr  = rdi_ff;
      wdata  = rd_ff;
      if (state_ff == ST_IDLE) begin
         waddr = head_ff + count_ff[IdxW-1:0];
         wdata.number    = req_data.pkt_number;
         wdata.size      = req_data.pkt_size;
         wdata.sent_time = req_data.time_stamp;
         wdata.ack_time  = 32'd0;
         mem_we = req_valid && req_ready && req_data.cmd == CMD_SENT
                  && count_ff < CntW'(TableDepth);
      end else if (state_ff == ST_ACK && rdv_ff && !(req_ff.gap_valid
                   && rd_ff.number <= req_ff.gap_bound)
                   && rd_ff.number <= req_ff.pkt_number && !cf[0]) begin
         wdata.ack_time = req_ff.time_stamp;
         mem_we = 1'b1;
      end
      if (state_ff == ST_SUM || state_ff == ST_MARK)
         raddr = head_ff + pos_ff[IdxW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         largest_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         rdv_ff       <= 1'b0;
         for (int i = 0; i < TableDepth; i++) flags_ff[i] <= 3'b000;
      end else begin
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               rdv_ff <= 1'b0;
               if (req_valid && req_ready) begin
                  req_ff   <= req_data;
                  lostc_ff <= '0;
                  bif_ff   <= '0;
                  found_ff <= 1'b0;
                  lostm_ff <= 1'b0;
                  outst_ff <= 1'b0;
                  case (req_data.cmd)
                     CMD_SENT: begin
                        rsp_ff <= {KIND_SENT, req_data.pkt_number, req_data.pkt_size,
                                   6'd0, 21'd0, (count_ff < CntW'(TableDepth)), 1'b1};
                        rsp_valid_ff <= 1'b1;
                        if (count_ff < CntW'(TableDepth)) begin
                           flags_ff[head_ff + count_ff[IdxW-1:0]] <=
                              {req_data.counts_in_flight, 2'b00};
                           count_ff <= count_ff + CntW'(1);
                        end
                     end
                     CMD_ACK: begin
                        if (req_data.first_block) largest_ff <= req_data.pkt_number;
                        pos_ff   <= count_ff;
                        state_ff <= ST_ACK;
                     end
                     CMD_LOST: begin
                        pos_ff   <= '0;
                        state_ff <= ST_MARK;
                     end
                     default: ;
                  endcase
               end
            end
            // newest to oldest; a hit stalls in ST_ACKW until its response goes
            ST_ACK: begin
               if (rdv_ff && req_ff.gap_valid && rd_ff.number <= req_ff.gap_bound) begin
                  rdv_ff   <= 1'b0;
                  state_ff <= ST_OUT;
               end else if (rdv_ff && rd_ff.number <= req_ff.pkt_number && !cf[0]) begin
                  rdv_ff <= 1'b0;
                  flags_ff[rdi_ff][0] <= 1'b1;
                  rsp_ff <= {KIND_ACKED, rd_ff.number, rd_ff.size, 6'd0, 21'd0,
                             1'b0, 1'b0};
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_ACKW;
               end else if (pos_ff == '0) begin
                  rdv_ff   <= 1'b0;
                  state_ff <= ST_OUT;
               end else begin
                  rdv_ff <= 1'b1;
                  rdi_ff <= cur_slot;
                  pos_ff <= pos_ff - CntW'(1);
               end
            end
            ST_ACKW: begin
               if (!rsp_valid_ff) state_ff <= ST_ACK;
            end
            // end of ack walk: loss scan or straight to summary
            ST_OUT: begin
               rdv_ff <= 1'b0;
               if (!rsp_valid_ff) begin
                  pos_ff   <= req_ff.last_block ? count_ff : '0;
                  state_ff <= req_ff.last_block ? ST_LOSS : ST_SUM;
               end
            end
            ST_LOSS: begin
               rdv_ff <= (pos_ff != '0);
               if (rdv_ff) begin
                  if (lostm_ff) begin
                     if (!cf[0]) flags_ff[rdi_ff][1] <= 1'b1;
                  end else if (rd_ff.number == largest_ff) begin
                     refack_ff <= rd_ff.ack_time;
                     outst_ff  <= 1'b1;
                  end else if (outst_ff && !cf[0]) begin
                     if (dist_hit || time_hit) begin
                        flags_ff[rdi_ff][1] <= 1'b1;
                        lostm_ff <= 1'b1;
                     end
                  end
               end
               if (pos_ff == '0) begin
                  if (!rdv_ff) state_ff <= ST_CLEAN;
               end else begin
                  rdi_ff <= cur_slot;
                  pos_ff <= pos_ff - CntW'(1);
               end
            end
            ST_CLEAN: begin
               if (count_ff != '0 && flags_ff[head_ff][0] && !flags_ff[head_ff][1]) begin
                  head_ff  <= head_ff + IdxW'(1);
                  count_ff <= count_ff - CntW'(1);
               end else begin
                  pos_ff   <= '0;
                  state_ff <= ST_SUM;
               end
            end
            // oldest to newest summary scan
            ST_SUM: begin
               rdv_ff <= (pos_ff != count_ff);
               if (rdv_ff) begin
                  if (cf[1]) lostc_ff <= lostc_ff + 6'd1;
                  if (cf[2] && !cf[0]) bif_ff <= bif_ff + 21'(rd_ff.size);
               end
               if (pos_ff == count_ff) begin
                  if (!rdv_ff) begin
                     rsp_ff <= {KIND_SUMMARY, 32'd0, 16'd0, lostc_ff, bif_ff,
                                1'b0, 1'b1};
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= ST_IDLE;
                  end
               end else begin
                  rdi_ff <= head_ff + pos_ff[IdxW-1:0];
                  pos_ff <= pos_ff + CntW'(1);
               end
            end
            ST_MARK: begin
               rdv_ff <= (pos_ff != count_ff);
               if (rdv_ff && rd_ff.number == req_ff.pkt_number) begin
                  flags_ff[rdi_ff][1] <= 1'b1;
                  found_ff <= 1'b1;
               end
               if (pos_ff == count_ff) begin
                  if (!rdv_ff) begin
                     rsp_ff <= {KIND_LOST, req_ff.pkt_number, 16'd0, 6'd0, 21'd0,
                                found_ff, 1'b1};
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= ST_IDLE;
                  end
               end else begin
                  rdi_ff <= head_ff + pos_ff[IdxW-1:0];
                  pos_ff <= pos_ff + CntW'(1);
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end
endmodule

FILE: hw/rtl/spal_checker.sv
// ----------------------------------------------------------------------------
// spal_checker
// Port-level checks of the tracker, bound to the tracker module.
// ----------------------------------------------------------------------------
`include "sent_packet_ack_loss_tracker_assert.svh"
module spal_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input spal_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input spal_pkg::rsp_type rsp_data
);
   import spal_pkg::*;
   `SPAL_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))
   `SPAL_ASSERT_NEXT(a_one_req, clock, reset, req_valid && req_ready && req_data.cmd != CMD_NONE, !req_ready)
   `SPAL_ASSERT_IMPL(a_acked_not_last, clock, reset, rsp_valid && rsp_data.kind == KIND_ACKED, !rsp_data.last)
   `SPAL_ASSERT_IMPL(a_final_last, clock, reset, rsp_valid && rsp_data.kind != KIND_ACKED, rsp_data.last)
endmodule

bind sent_packet_ack_loss_tracker spal_checker u_spal_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .req_data(req_data), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
   .rsp_data(rsp_data)
);

FILE: bench/sent_packet_ack_loss_tracker_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sent_packet_ack_loss_tracker_test
// Self-checking bench for the sent-packet ack and loss tracker: a directed
// table of requests, then random sent records, ack block runs, mark-lost and
// noise requests under several register settings, checked against a predictor.
// ----------------------------------------------------------------------------
module sent_packet_ack_loss_tracker_test;
   import spal_pkg::*;

   localparam int Depth = TableDepth;
   localparam int SettleCycles = 120;
   localparam int FlagAcked = 0;
   localparam int FlagLost = 1;
   localparam int FlagInFlight = 2;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic    csr_we = 1'b0;
   logic    csr_index = 1'b0;
   logic [7:0] csr_wdata = '0;

   sent_packet_ack_loss_tracker uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // mirror of the packet table
   logic [31:0] tbl_number [Depth];
   logic [15:0] tbl_size [Depth];
   logic [31:0] tbl_sent [Depth];
   logic [31:0] tbl_ack [Depth];
   logic [2:0]  tbl_flags [Depth];
   int unsigned tbl_head = 0;
   int unsigned tbl_count = 0;
   logic [31:0] largest_acked = '0;
   logic [7:0]  reorder_thr = 8'd3;
   logic        time_loss_on = 1'b0;

   rsp_type expected_rsps [$];
   int          fail_count = 0;
   bit          hold_pending = 1'b0;
   logic [31:0] next_number = 32'd100;
   logic [31:0] tick = 32'd1000;

   typedef struct {
      req_type req;
      bit      typed;
      rsp_type rsp;
   } row_type;
   row_type directed_rows [$];

   function automatic int unsigned slot_of(int unsigned i);
      return (tbl_head + i) % Depth;
   endfunction

   function automatic rsp_type make_rsp(logic [1:0] kind, logic [31:0] num,
         logic [15:0] size, logic [5:0] lostc, logic [20:0] bif, logic ok,
         logic lst);
      rsp_type r;
      r.kind = kind; r.out_number = num; r.out_size = size;
      r.lost_count = lostc; r.bytes_in_flight = bif; r.ok_flag = ok;
      r.last = lst;
      return r;
   endfunction

   // append one expected response
   function automatic void queue_rsp(rsp_type x);
      expected_rsps.insert(expected_rsps.size(), x);
   endfunction

   // number and time based loss marking, newest to oldest
   function automatic void mark_losses(logic [31:0] thr);
      bit          declared;
      bit          outstanding;
      int unsigned ref_s;
      int unsigned s;
      logic [31:0] num_behind;
      longint      dt;
      declared = 0; outstanding = 0; ref_s = 0;
      for (int i = tbl_count; i > 0; i--) begin
         s = slot_of(i - 1);
         if (declared) begin
            if (!tbl_flags[s][FlagAcked]) tbl_flags[s][FlagLost] = 1'b1;
         end else if (tbl_number[s] == largest_acked) begin
            ref_s = s;
            outstanding = 1;
         end else if (outstanding && !tbl_flags[s][FlagAcked]) begin
            num_behind = largest_acked - tbl_number[s];
            if (num_behind >= {24'd0, reorder_thr}) begin
               tbl_flags[s][FlagLost] = 1'b1;
               declared = 1;
            end
            if (time_loss_on) begin
               dt = longint'({32'd0, tbl_ack[ref_s]}) - longint'({32'd0, tbl_sent[s]});
               if (dt >= longint'({32'd0, thr})) begin
                  tbl_flags[s][FlagLost] = 1'b1;
                  declared = 1;
               end
            end
         end
      end
   endfunction

   // update the mirror for an accepted request and queue its responses
   function automatic void predict_rsps(req_type r);
      int unsigned s;
      logic        ok;
      logic [5:0]  lostc;
      logic [20:0] bif;
      case (r.cmd)
         CMD_SENT: begin
            ok = 1'b0;
            if (tbl_count < Depth) begin
               s = slot_of(tbl_count);
               tbl_number[s] = r.pkt_number;
               tbl_size[s] = r.pkt_size;
               tbl_sent[s] = r.time_stamp;
               tbl_ack[s] = '0;
               tbl_flags[s] = '0;
               tbl_flags[s][FlagInFlight] = r.counts_in_flight;
               tbl_count++;
               ok = 1'b1;
            end
            queue_rsp(make_rsp(KIND_SENT, r.pkt_number, r.pkt_size, '0, '0, ok, 1'b1));
         end
         CMD_ACK: begin
            if (r.first_block) largest_acked = r.pkt_number;
            for (int i = tbl_count; i > 0; i--) begin
               s = slot_of(i - 1);
               if (r.gap_valid && tbl_number[s] <= r.gap_bound) break;
               if (tbl_number[s] <= r.pkt_number && !tbl_flags[s][FlagAcked]) begin
                  tbl_flags[s][FlagAcked] = 1'b1;
                  tbl_ack[s] = r.time_stamp;
                  queue_rsp(make_rsp(KIND_ACKED, tbl_number[s], tbl_size[s], '0, '0,
                                     1'b0, 1'b0));
               end
            end
            if (r.last_block) begin
               mark_losses(r.time_threshold);
               // drop acked, not lost entries from the head
               while (tbl_count > 0 && tbl_flags[tbl_head][FlagAcked]
                      && !tbl_flags[tbl_head][FlagLost]) begin
                  tbl_head = (tbl_head + 1) % Depth;
                  tbl_count--;
               end
            end
            lostc = '0; bif = '0;
            for (int i = 0; i < tbl_count; i++) begin
               s = slot_of(i);
               if (tbl_flags[s][FlagLost]) lostc++;
               if (tbl_flags[s][FlagInFlight] && !tbl_flags[s][FlagAcked])
                  bif += 21'(tbl_size[s]);
            end
            queue_rsp(make_rsp(KIND_SUMMARY, '0, '0, lostc, bif, 1'b0, 1'b1));
         end
         CMD_LOST: begin
            ok = 1'b0;
            for (int i = 0; i < tbl_count; i++) begin
               s = slot_of(i);
               if (tbl_number[s] == r.pkt_number) begin
                  tbl_flags[s][FlagLost] = 1'b1;
                  ok = 1'b1;
               end
            end
            queue_rsp(make_rsp(KIND_LOST, r.pkt_number, '0, '0, '0, ok, 1'b1));
         end
         default: ;
      endcase
   endfunction

   function automatic req_type make_req(logic [1:0] cmd, logic [31:0] num,
         logic [15:0] size, logic [31:0] ts, logic infl, logic [31:0] gap,
         logic gv, logic first, logic lst, logic [31:0] thr);
      req_type r;
      r.cmd = cmd; r.pkt_number = num; r.pkt_size = size; r.time_stamp = ts;
      r.counts_in_flight = infl; r.gap_bound = gap; r.gap_valid = gv;
      r.first_block = first; r.last_block = lst; r.time_threshold = thr;
      return r;
   endfunction

   function automatic void add_row(req_type r, bit typed, rsp_type x);
      row_type w;
      w.req = r; w.typed = typed; w.rsp = x;
      directed_rows.insert(directed_rows.size(), w);
   endfunction

   // offer one request and hold it until taken; a typed answer replaces the
   // predicted one
   task automatic send_req(req_type r, bit typed, rsp_type x);
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_rsps(r);
      if (typed) expected_rsps[expected_rsps.size() - 1] = x;
      // bursts with random gaps
      if ($urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   task automatic write_csr(logic idx, logic [7:0] value);
      req_valid <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
      csr_we <= 1'b1; csr_index <= idx; csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == REG_REORDER) reorder_thr = value;
      else time_loss_on = value[0];
   endtask

   // random traffic: mostly sent records and ack runs, some noise
   task automatic run_traffic(int n_items);
      int          done;
      int          n_blk;
      int unsigned pick;
      logic [31:0] hi;
      logic [31:0] lo;
      logic [191:0] noise;
      rsp_type     none;
      req_type     r;
      done = 0; none = '0;
      while (done < n_items) begin
         pick = $urandom_range(0, 99);
         tick += $urandom_range(1, 40);
         if (pick < 50) begin
            if ($urandom_range(0, 9) == 0) r = make_req(CMD_SENT, next_number - 2,
               16'($urandom), tick, 1'($urandom), $urandom, 1'($urandom),
               1'($urandom), 1'($urandom), $urandom);
            else r = make_req(CMD_SENT, next_number, 16'($urandom_range(0, 1500)), tick,
               $urandom_range(0, 4) != 0, $urandom, 1'($urandom), 1'($urandom),
               1'($urandom), $urandom);
            next_number += $urandom_range(1, 2);
            send_req(r, 1'b0, none);
            done++;
         end else if (pick < 80) begin
            n_blk = $urandom_range(1, 3);
            hi = next_number - 1 - $urandom_range(0, 2);
            for (int b = 0; b < n_blk; b++) begin
               lo = hi - $urandom_range(0, 3);
               r = make_req(CMD_ACK, hi, 16'($urandom), tick, 1'($urandom), lo - 1,
                            b != n_blk - 1, b == 0, b == n_blk - 1,
                            $urandom_range(0, 200));
               send_req(r, 1'b0, none);
               hi = lo - 2 - $urandom_range(0, 2);
               done++;
            end
         end else if (pick < 88) begin
            r = make_req(CMD_LOST, next_number - $urandom_range(1, 12), 16'($urandom),
                         $urandom, 1'($urandom), $urandom, 1'($urandom), 1'($urandom),
                         1'($urandom), $urandom);
            send_req(r, 1'b0, none);
            done++;
         end else begin
            noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
            r = noise[$bits(req_type)-1:0];
            send_req(r, 1'b0, none);
            if (r.cmd != CMD_NONE) done++;
         end
      end
   endtask

   // result checker
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsps.size() == 0) begin
            $error("unexpected response %p", rsp_data);
            fail_count++;
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_data.kind !== want.kind) begin
               $error("kind: expected %0d, got %0d", want.kind, rsp_data.kind);
               fail_count++;
            end
            if (rsp_data.out_number !== want.out_number) begin
               $error("out_number: expected %0h, got %0h", want.out_number,
                      rsp_data.out_number);
               fail_count++;
            end
            if (rsp_data.out_size !== want.out_size) begin
               $error("out_size: expected %0d, got %0d", want.out_size,
                      rsp_data.out_size);
               fail_count++;
            end
            if (rsp_data.lost_count !== want.lost_count) begin
               $error("lost_count: expected %0d, got %0d", want.lost_count,
                      rsp_data.lost_count);
               fail_count++;
            end
            if (rsp_data.bytes_in_flight !== want.bytes_in_flight) begin
               $error("bytes_in_flight: expected %0d, got %0d", want.bytes_in_flight,
                      rsp_data.bytes_in_flight);
               fail_count++;
            end
            if (rsp_data.ok_flag !== want.ok_flag) begin
               $error("ok_flag: expected %0b, got %0b", want.ok_flag, rsp_data.ok_flag);
               fail_count++;
            end
            if (rsp_data.last !== want.last) begin
               $error("last: expected %0b, got %0b", want.last, rsp_data.last);
               fail_count++;
            end
         end
      end
   end

   // receiver: randomly chosen stall patterns in turn, plus one long hold
   initial begin
      int mode;
      int age;
      mode = 0; age = 0;
      forever begin
         @(posedge clock);
         if (hold_pending) begin
            hold_pending = 1'b0;
            rsp_ready <= 1'b0;
            repeat (300) @(posedge clock);
         end else begin
            if (age == 0) mode = $urandom_range(0, 2);
            age = (age + 1) % 64;
            case (mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= $urandom_range(0, 3) != 0;
               default: rsp_ready <= $urandom_range(0, 3) == 0;
            endcase
         end
      end
   end

   initial begin
      #10_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   // stimulus
   initial begin
      rsp_type none;
      none = '0;
      add_row(make_req(CMD_SENT, 32'd0, 16'd0, 32'd0, 1'b0, '0, 1'b0, 1'b0, 1'b0, '0),
              1'b1, make_rsp(KIND_SENT, 32'd0, 16'd0, '0, '0, 1'b1, 1'b1));
      add_row(make_req(CMD_SENT, '1, '1, '1, 1'b1, '1, 1'b1, 1'b1, 1'b1, '1),
              1'b1, make_rsp(KIND_SENT, '1, '1, '0, '0, 1'b1, 1'b1));
      add_row(make_req(CMD_SENT, 32'd1, 16'd100, 32'd10, 1'b1, '0, 1'b0, 1'b0, 1'b0, '0),
              1'b0, none);
      add_row(make_req(CMD_SENT, 32'd2, 16'd200, 32'd20, 1'b1, '0, 1'b0, 1'b0, 1'b0, '0),
              1'b0, none);
      add_row(make_req(CMD_SENT, 32'd3, 16'd300, 32'd30, 1'b0, '0, 1'b0, 1'b0, 1'b0, '0),
              1'b0, none);
      add_row(make_req(CMD_SENT, 32'd7, 16'd50, 32'd40, 1'b1, '0, 1'b0, 1'b0, 1'b0, '0),
              1'b0, none);
      add_row(make_req(CMD_SENT, 32'd9, 16'd60, 32'd50, 1'b1, '0, 1'b0, 1'b0, 1'b0, '0),
              1'b0, none);
      add_row(make_req(CMD_SENT, 32'd9, 16'd70, 32'd60, 1'b1, '0, 1'b0, 1'b0, 1'b0, '0),
              1'b0, none);
      add_row(make_req(CMD_LOST, 32'd12345, '0, '0, 1'b0, '0, 1'b0, 1'b0, 1'b0, '0),
              1'b1, make_rsp(KIND_LOST, 32'd12345, '0, '0, '0, 1'b0, 1'b1));
      // unknown command, no answer
      add_row(make_req(CMD_NONE, '1, '1, '1, 1'b1, '1, 1'b1, 1'b1, 1'b1, '1), 1'b0, none);
      // duplicate numbers on mark-lost
      add_row(make_req(CMD_LOST, 32'd9, '0, '0, 1'b0, '0, 1'b0, 1'b0, 1'b0, '0),
              1'b0, none);
      add_row(make_req(CMD_ACK, 32'd7, '0, 32'd90, 1'b0, 32'd3, 1'b1, 1'b1, 1'b0, '0),
              1'b0, none);
      add_row(make_req(CMD_ACK, 32'd2, '0, 32'd100, 1'b0, '0, 1'b0, 1'b0, 1'b1, '0),
              1'b0, none);
      add_row(make_req(CMD_LOST, 32'd3, '0, '0, 1'b0, '0, 1'b0, 1'b0, 1'b0, '0),
              1'b0, none);
      add_row(make_req(CMD_ACK, '1, '1, '1, 1'b1, '1, 1'b0, 1'b1, 1'b1, '1), 1'b0, none);
      add_row(make_req(CMD_ACK, 32'd0, '0, '0, 1'b0, '0, 1'b1, 1'b0, 1'b1, '0),
              1'b0, none);

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed_rows[i])
         send_req(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].rsp);

      // wide reorder window, no time test; long receiver hold at the start
      write_csr(REG_REORDER, 8'd255);
      write_csr(REG_TIMELOSS, 8'd0);
      hold_pending = 1'b1;
      run_traffic(130);
      // narrow window with the time test
      write_csr(REG_REORDER, 8'd1);
      write_csr(REG_TIMELOSS, 8'd1);
      run_traffic(60);
      // random setting
      write_csr(REG_REORDER, 8'($urandom_range(2, 254)));
      write_csr(REG_TIMELOSS, 8'($urandom_range(0, 1)));
      run_traffic(70);

      req_valid <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
      if (fail_count == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end
endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/spal_pkg.sv
hw/rtl/sent_packet_ack_loss_tracker.sv
hw/rtl/spal_checker.sv
bench/sent_packet_ack_loss_tracker_test.sv
